// ----- sv/brfps_pkg.sv -----
// shared widths, operation codes and controller command type
`default_nettype none

package brfps_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int KIND_W    = 2;
  localparam int BYTE_W    = 8;
  localparam int CNT_W     = 11;

  // operation codes carried in the kind field
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SKIP  = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic cap;
    logic exec;
    logic load;
  } cmd_t;

endpackage

`default_nettype wire

// ----- sv/brfps_if.sv -----
// valid/ready channel interfaces for operation words and result words
`default_nettype none

interface brfps_in_if import brfps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] data_byte;
  logic [CNT_W-1:0]  amount;

  modport source (output valid, kind, data_byte, amount, input ready);
  modport sink   (input valid, kind, data_byte, amount, output ready);
endinterface

interface brfps_out_if import brfps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_out;
  logic              done_res;
  logic [CNT_W-1:0]  skipped;
  logic [CNT_W-1:0]  fill_level;
  logic [CNT_W-1:0]  free_space;

  modport source (output valid, data_out, done_res, skipped, fill_level, free_space,
                  input ready);
  modport sink   (input valid, data_out, done_res, skipped, fill_level, free_space,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/brfps_ctrl.sv -----
// controller: sequences capture, execute and result load of one word
`default_nettype none

module brfps_ctrl import brfps_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // commands
  assign in_ready = (state == ST_IDLE);
  assign cmd.cap  = (state == ST_IDLE) && in_valid;
  assign cmd.exec = (state == ST_EXEC);
  assign cmd.load = (state == ST_HOLD) && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state and output slot occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/brfps_dp.sv -----
// datapath: byte store, positions, fill count and result register
`default_nettype none

module brfps_dp import brfps_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CNT_W-1:0]  cfg_wdata,
  input  wire cmd_t              cmd,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic [CNT_W-1:0]  amount,
  output logic [BYTE_W-1:0]      data_out,
  output logic                   done_res,
  output logic [CNT_W-1:0]       skipped,
  output logic [CNT_W-1:0]       fill_level,
  output logic [CNT_W-1:0]       free_space
);

  // the size register never exceeds the count width, so only that many slots are reachable
  localparam int CNT_MAX  = (1 << CNT_W) - 1;
  localparam int SIZE_MAX = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;
  localparam int AW       = $clog2(SIZE_MAX);
  localparam int SW       = CNT_W + 1;
  localparam logic [CNT_W-1:0] SIZE_TOP = CNT_W'(SIZE_MAX);
  localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

  function automatic logic [CNT_W-1:0] wrap(input logic [SW-1:0] s,
                                            input logic [CNT_W-1:0] sz);
    logic [SW-1:0] szx;
    szx  = {1'b0, sz};
    wrap = (s >= szx) ? CNT_W'(s - szx) : CNT_W'(s);
  endfunction

  logic [BYTE_W-1:0] mem [SIZE_MAX];

  logic [CNT_W-1:0]  size_reg;
  logic [CNT_W-1:0]  rd_pos;
  logic [CNT_W-1:0]  wr_pos;
  logic [CNT_W-1:0]  fill;

  logic [KIND_W-1:0] item_kind;
  logic [BYTE_W-1:0] item_byte;
  logic [CNT_W-1:0]  item_amount;

  logic [BYTE_W-1:0] rd_q;
  logic              res_ok;
  logic              res_take;
  logic [CNT_W-1:0]  res_skip;
  logic [CNT_W-1:0]  res_fill;
  logic [CNT_W-1:0]  res_free;

  logic [CNT_W-1:0]  eff;
  logic [CNT_W-1:0]  wr_inc;
  logic [CNT_W-1:0]  rd_inc;
  logic [CNT_W-1:0]  peek_pos;
  logic [CNT_W-1:0]  skip_n;
  logic [CNT_W-1:0]  skip_pos;
  logic [CNT_W-1:0]  rd_addr;
  logic [CNT_W-1:0]  rd_pos_next;
  logic [CNT_W-1:0]  wr_pos_next;
  logic [CNT_W-1:0]  fill_next;
  logic [CNT_W-1:0]  skip_cnt;
  logic              ok;
  logic              take;
  logic              mem_we;

  // effective size: zero acts as one, oversize clamps to the store
  always_comb begin
    if (size_reg == '0) begin
      eff = ONE;
    end else if (size_reg > SIZE_TOP) begin
      eff = SIZE_TOP;
    end else begin
      eff = size_reg;
    end
  end

  // candidate positions, each wrapped once at the effective size
  assign wr_inc   = wrap({1'b0, wr_pos} + SW'(1), eff);
  assign rd_inc   = wrap({1'b0, rd_pos} + SW'(1), eff);
  assign peek_pos = wrap({1'b0, rd_pos} + {1'b0, item_amount}, eff);
  assign skip_n   = (item_amount < fill) ? item_amount : fill;
  assign skip_pos = wrap({1'b0, rd_pos} + {1'b0, skip_n}, eff);
  assign rd_addr  = (item_kind == KIND_READ) ? rd_pos : peek_pos;

  // operation decode
  always_comb begin
    rd_pos_next = rd_pos;
    wr_pos_next = wr_pos;
    fill_next   = fill;
    skip_cnt    = '0;
    ok          = 1'b0;
    take        = 1'b0;
    mem_we      = 1'b0;
    case (item_kind)
      KIND_WRITE: begin
        if (fill < eff) begin
          mem_we      = 1'b1;
          wr_pos_next = wr_inc;
          fill_next   = fill + ONE;
          ok          = 1'b1;
        end
      end
      KIND_READ: begin
        if (fill != '0) begin
          take        = 1'b1;
          rd_pos_next = rd_inc;
          fill_next   = fill - ONE;
          ok          = 1'b1;
        end
      end
      KIND_PEEK: begin
        if (item_amount < fill) begin
          take = 1'b1;
          ok   = 1'b1;
        end
      end
      KIND_SKIP: begin
        rd_pos_next = skip_pos;
        fill_next   = fill - skip_n;
        skip_cnt    = skip_n;
        ok          = (skip_n == item_amount);
      end
      default: begin
      end
    endcase
  end

  // size register and positions; a size write empties the fifo
  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SIZE_TOP;
      rd_pos   <= '0;
      wr_pos   <= '0;
      fill     <= '0;
    end else if (cfg_we) begin
      size_reg <= cfg_wdata;
      rd_pos   <= '0;
      wr_pos   <= '0;
      fill     <= '0;
    end else if (cmd.exec) begin
      rd_pos <= rd_pos_next;
      wr_pos <= wr_pos_next;
      fill   <= fill_next;
    end
  end

  // byte store with registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem[wr_pos[AW-1:0]] <= item_byte;
    end
    if (cmd.exec) begin
      rd_q <= mem[rd_addr[AW-1:0]];
    end
  end

  // captured operation word
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      item_kind   <= kind;
      item_byte   <= data_byte;
      item_amount <= amount;
    end
  end

  // result fields held until the byte comes back from the store
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_ok   <= ok;
      res_take <= take;
      res_skip <= skip_cnt;
      res_fill <= fill_next;
      res_free <= eff - fill_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data_out   <= res_take ? rd_q : '0;
      done_res   <= res_ok;
      skipped    <= res_skip;
      fill_level <= res_fill;
      free_space <= res_free;
    end
  end

endmodule

`default_nettype wire

// ----- sv/byte_ring_fifo_peek_skip_unit.sv -----
// Circular byte fifo with peek and skip, sized at run time.
// Channel in_ch carries one operation word: kind (write, read, peek, skip),
// data_byte for writes and amount for peek offsets and skip counts.
// Channel out_ch returns exactly one result word per operation: the byte read
// or peeked, a done flag, the count skipped, and fill level and free space.
// cfg_we/cfg_wdata write the size register (1 to DEPTH slots in use, at most
// 2047); a write empties the fifo. The user must do a write only while no
// operation is in flight; the block itself does not enforce it.
// Each operation passes through capture, execute with the store read, then
// load into the output register, fed by the synchronous store read. A new
// operation is taken once the previous result sits in the output register,
// so a result waiting on a stalled receiver does not block the next operation
// from executing, only from loading its result.
// Reset empties the fifo and sets the size to DEPTH (at most 2047); store
// contents stay undefined until written and no clearing pass is needed.
`default_nettype none

module byte_ring_fifo_peek_skip_unit import brfps_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  brfps_in_if.sink              in_ch,
  brfps_out_if.source           out_ch
);

  localparam int CNT_MAX  = (1 << CNT_W) - 1;
  localparam int SIZE_MAX = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;

  cmd_t cmd;
  logic in_ready;
  logic out_valid;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  // controller
  brfps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // datapath
  brfps_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .kind       (in_ch.kind),
    .data_byte  (in_ch.data_byte),
    .amount     (in_ch.amount),
    .data_out   (out_ch.data_out),
    .done_res   (out_ch.done_res),
    .skipped    (out_ch.skipped),
    .fill_level (out_ch.fill_level),
    .free_space (out_ch.free_space)
  );

  // an accepted word is executed on the next cycle
  a_cap_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.cap |=> cmd.exec)
    else $error("accepted word not executed");

  // at most one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.cap, cmd.exec, cmd.load}))
    else $error("overlapping commands");

  // fill plus free never exceeds the largest usable size
  a_fill_free: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, out_ch.fill_level} + {1'b0, out_ch.free_space})
                  <= (CNT_W+1)'(SIZE_MAX))
    else $error("fill level and free space inconsistent");

  // a skip never returns a byte
  a_skip_no_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_ch.skipped != '0)) |-> (out_ch.data_out == '0))
    else $error("skip result carries data");

endmodule

`default_nettype wire
